### rtl/mhurs_pkg.sv
// ----------------------------------------------------------------------------
// mhurs_pkg - shared types and constants for the received-header scanner
// Scan phase encoding, character codes and keyword match helpers.
// ----------------------------------------------------------------------------
package mhurs_pkg;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_NAME     = 3'd1,
        PH_OTHER    = 3'd2,
        PH_RCVD     = 3'd3,
        PH_ARG      = 3'd4,
        PH_AFTER    = 3'd5,
        PH_LINE_END = 3'd6
    } phase_t;

    typedef logic [3:0] pos_t;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    localparam int NAME_LEN = 9;
    localparam int WITH_LEN = 6;
    localparam int ARG_LEN  = 4;

    localparam logic [7:0] NAME_UP [NAME_LEN] = '{"R","E","C","E","I","V","E","D",":"};
    localparam logic [7:0] NAME_LO [NAME_LEN] = '{"r","e","c","e","i","v","e","d",":"};
    localparam logic [7:0] WITH_UP [WITH_LEN] = '{" ","W","I","T","H"," "};
    localparam logic [7:0] WITH_LO [WITH_LEN] = '{" ","w","i","t","h"," "};
    localparam logic [7:0] ARG_UP  [ARG_LEN]  = '{"U","T","F","8"};
    localparam logic [7:0] ARG_LO  [ARG_LEN]  = '{"u","t","f","8"};

    // position past the keyword end never matches
    function automatic logic name_hit(input pos_t pos, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (pos < 4'(NAME_LEN)) begin
            hit = (b == NAME_UP[pos]) || (b == NAME_LO[pos]);
        end
        return hit;
    endfunction

    function automatic logic with_hit(input pos_t pos, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (pos < 4'(WITH_LEN)) begin
            hit = (b == WITH_UP[pos[2:0]]) || (b == WITH_LO[pos[2:0]]);
        end
        return hit;
    endfunction

    function automatic logic arg_hit(input pos_t pos, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (pos < 4'(ARG_LEN)) begin
            hit = (b == ARG_UP[pos[1:0]]) || (b == ARG_LO[pos[1:0]]);
        end
        return hit;
    endfunction

endpackage

### rtl/mail_header_utf8_received_scanner.sv
// ----------------------------------------------------------------------------
// mail_header_utf8_received_scanner - received-field utf8 clause detector
// result path: input reg, then state/result reg
// throughput: one byte per cycle while m_ready does not hold the result slot
// reset: synchronous active-low aresetn clears scan state, flags and both valids
// ----------------------------------------------------------------------------
// Scans mail header bytes for a Received field whose with-clause names UTF8.
// Each accepted byte yields one result transaction with the sticky flags.
// ----------------------------------------------------------------------------
module mail_header_utf8_received_scanner (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_utf8_found,
    output logic       m_scan_done
);

    // input stage
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;

    // scan state; the flags double as the result register
    mhurs_pkg::phase_t   phase_reg, phase_next;
    mhurs_pkg::pos_t     pos_reg, pos_next;
    logic                utf8_reg, utf8_next;
    logic                done_reg, done_next;
    logic                out_valid_reg;

    logic                advance;
    logic [7:0]          b;
    mhurs_pkg::phase_t   ph;
    mhurs_pkg::pos_t     pos;
    logic                run;

    // byte moves into the result stage when the result slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid      = out_valid_reg;
    assign m_utf8_found = utf8_reg;
    assign m_scan_done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= mhurs_pkg::PH_START;
            pos_reg       <= '0;
            utf8_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                utf8_reg  <= utf8_next;
                done_reg  <= done_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // next scan state for the byte in the input stage
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        utf8_next  = utf8_reg;
        done_next  = done_reg;
        // tabs count as blanks
        b   = (in_byte_reg == mhurs_pkg::CHAR_TAB) ? mhurs_pkg::CHAR_SP : in_byte_reg;
        ph  = phase_reg;
        pos = pos_reg;
        // finished scan and carriage returns leave everything alone
        run = !done_reg && (in_byte_reg != mhurs_pkg::CHAR_CR);

        // line end inside Received: a blank folds the line back into the with-search,
        // and that blank already counts as the leading space of " with "
        if (run && ph == mhurs_pkg::PH_LINE_END) begin
            if (b == mhurs_pkg::CHAR_SP) begin
                phase_next = mhurs_pkg::PH_RCVD;
                pos_next   = 4'd1;
                run        = 1'b0;
            end else begin
                ph = mhurs_pkg::PH_START;
            end
        end

        // start of a field (unused encoding behaves the same)
        if (run && ph != mhurs_pkg::PH_NAME && ph != mhurs_pkg::PH_OTHER &&
            ph != mhurs_pkg::PH_RCVD && ph != mhurs_pkg::PH_ARG &&
            ph != mhurs_pkg::PH_AFTER) begin
            if (b == mhurs_pkg::CHAR_LF) begin
                // empty line closes the header
                done_next = 1'b1;
                run       = 1'b0;
            end else begin
                ph         = mhurs_pkg::PH_NAME;
                pos        = '0;
                phase_next = mhurs_pkg::PH_NAME;
                pos_next   = '0;
            end
        end

        if (run) begin
            unique case (ph)
                mhurs_pkg::PH_NAME: begin
                    if (!mhurs_pkg::name_hit(pos, b)) begin
                        phase_next = mhurs_pkg::PH_OTHER;
                    end else if (pos == 4'(mhurs_pkg::NAME_LEN - 1)) begin
                        phase_next = mhurs_pkg::PH_RCVD;
                        pos_next   = '0;
                    end else begin
                        phase_next = mhurs_pkg::PH_NAME;
                        pos_next   = pos + 4'd1;
                    end
                end
                mhurs_pkg::PH_OTHER: begin
                    if (b == mhurs_pkg::CHAR_LF) begin
                        phase_next = mhurs_pkg::PH_START;
                    end
                end
                mhurs_pkg::PH_RCVD: begin
                    if (b == mhurs_pkg::CHAR_LF) begin
                        phase_next = mhurs_pkg::PH_LINE_END;
                    end else if (!mhurs_pkg::with_hit(pos, b)) begin
                        // restart without retrying this byte
                        pos_next = '0;
                    end else if (pos == 4'(mhurs_pkg::WITH_LEN - 1)) begin
                        phase_next = mhurs_pkg::PH_ARG;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos + 4'd1;
                    end
                end
                mhurs_pkg::PH_ARG: begin
                    if (pos == '0 && b == mhurs_pkg::CHAR_SP) begin
                        // leading blanks before the argument are skipped
                    end else if (!mhurs_pkg::arg_hit(pos, b)) begin
                        phase_next = mhurs_pkg::PH_AFTER;
                    end else begin
                        pos_next = pos + 4'd1;
                        if (pos == 4'(mhurs_pkg::ARG_LEN - 1)) begin
                            utf8_next  = 1'b1;
                            phase_next = mhurs_pkg::PH_AFTER;
                        end
                    end
                end
                mhurs_pkg::PH_AFTER: begin
                    if (b == mhurs_pkg::CHAR_LF) begin
                        done_next = 1'b1;
                    end else begin
                        // byte is consumed, name matching resumes on the next one
                        phase_next = mhurs_pkg::PH_NAME;
                        pos_next   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // done flag never drops once set
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("scan_done dropped");

    // utf8 flag never drops once set
    a_utf8_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        utf8_reg |=> utf8_reg)
        else $error("utf8_found dropped");

    // after the scan ends the phase and the utf8 flag are frozen
    a_done_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> $stable(phase_reg) && $stable(utf8_reg))
        else $error("state changed after scan end");

    // an empty result slot never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result slot");
`endif

endmodule

### verif/tb_mail_header_utf8_received_scanner.sv
// ----------------------------------------------------------------------------
// tb_mail_header_utf8_received_scanner - self-checking bench for the scanner
// Streams header text into the scanner and scores every result transaction
// against a cycle-free scan predictor. Well-formed Received lines, folded
// with-clauses, other fields and noise, under several idle and stall mixes,
// one long receiver hold-off, and one header end followed by ignored bytes.
// ----------------------------------------------------------------------------
module tb_mail_header_utf8_received_scanner;

    // generous bound, far above the slowest legal run
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 90;
    localparam int MAX_REPORTS    = 40;
    localparam int ITEMS_PER_MIX  = 360;

    // predictor state, mirrors what the scanner keeps between bytes
    typedef struct packed {
        mhurs_pkg::phase_t phase;
        mhurs_pkg::pos_t   pos;
        logic              utf8;
        logic              done;
    } scan_state_t;

    // one result transaction as seen on the m_ side
    typedef struct packed {
        logic utf8_found;
        logic scan_done;
    } scan_flags_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_utf8_found;
    logic       m_scan_done;

    scan_state_t scan_state = '0;
    scan_flags_t pending_flags[$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;
    // while set, a byte that would end the header scan is swapped out
    bit  keep_alive    = 1'b1;

    mail_header_utf8_received_scanner u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_utf8_found (m_utf8_found),
        .m_scan_done  (m_scan_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // scan predictor
    // ------------------------------------------------------------------

    // keywords kept in lower case, each letter also matches its upper case
    function automatic logic kw_hit(input string kw, input mhurs_pkg::pos_t at,
                                    input logic [7:0] b);
        logic [7:0] c;
        if (int'(at) >= kw.len()) begin
            return 1'b0;
        end
        c = kw[at];
        return (b == c) || (c >= "a" && c <= "z" && b == c - 8'd32);
    endfunction

    // next scan state after one accepted header byte
    function automatic scan_state_t scan_next(input scan_state_t st, input logic [7:0] raw);
        scan_state_t       nx;
        logic [7:0]        b;
        mhurs_pkg::phase_t ph;
        nx = st;
        b  = raw;
        // frozen after the header end, carriage returns leave no trace
        if (st.done || raw == mhurs_pkg::CHAR_CR) begin
            return nx;
        end
        if (b == mhurs_pkg::CHAR_TAB) begin
            b = mhurs_pkg::CHAR_SP;
        end
        ph = st.phase;
        // line end inside Received: a blank folds the line and is the
        // leading blank of the with keyword, anything else opens a field
        if (ph == mhurs_pkg::PH_LINE_END) begin
            if (b == mhurs_pkg::CHAR_SP) begin
                nx.phase = mhurs_pkg::PH_RCVD;
                nx.pos   = 4'd1;
                return nx;
            end
            ph = mhurs_pkg::PH_START;
        end
        // start of a field, the unused encoding behaves the same way
        if (ph != mhurs_pkg::PH_NAME && ph != mhurs_pkg::PH_OTHER &&
            ph != mhurs_pkg::PH_RCVD && ph != mhurs_pkg::PH_ARG &&
            ph != mhurs_pkg::PH_AFTER) begin
            if (b == mhurs_pkg::CHAR_LF) begin
                nx.done = 1'b1;
                return nx;
            end
            ph       = mhurs_pkg::PH_NAME;
            nx.phase = mhurs_pkg::PH_NAME;
            nx.pos   = 4'd0;
        end
        case (ph)
            mhurs_pkg::PH_NAME: begin
                if (!kw_hit("received:", nx.pos, b)) begin
                    nx.phase = mhurs_pkg::PH_OTHER;
                end else if (nx.pos == 4'd8) begin
                    nx.phase = mhurs_pkg::PH_RCVD;
                    nx.pos   = 4'd0;
                end else begin
                    nx.pos = nx.pos + 4'd1;
                end
            end
            mhurs_pkg::PH_OTHER: begin
                if (b == mhurs_pkg::CHAR_LF) begin
                    nx.phase = mhurs_pkg::PH_START;
                end
            end
            mhurs_pkg::PH_RCVD: begin
                // a mismatch restarts the match without retrying the byte
                if (b == mhurs_pkg::CHAR_LF) begin
                    nx.phase = mhurs_pkg::PH_LINE_END;
                end else if (!kw_hit(" with ", nx.pos, b)) begin
                    nx.pos = 4'd0;
                end else if (nx.pos == 4'd5) begin
                    nx.phase = mhurs_pkg::PH_ARG;
                    nx.pos   = 4'd0;
                end else begin
                    nx.pos = nx.pos + 4'd1;
                end
            end
            mhurs_pkg::PH_ARG: begin
                // blanks ahead of the argument are skipped
                if (!(nx.pos == 4'd0 && b == mhurs_pkg::CHAR_SP)) begin
                    if (!kw_hit("utf8", nx.pos, b)) begin
                        nx.phase = mhurs_pkg::PH_AFTER;
                    end else if (nx.pos == 4'd3) begin
                        nx.utf8  = 1'b1;
                        nx.phase = mhurs_pkg::PH_AFTER;
                        nx.pos   = 4'd4;
                    end else begin
                        nx.pos = nx.pos + 4'd1;
                    end
                end
            end
            mhurs_pkg::PH_AFTER: begin
                // newline right after the argument ends the header,
                // any other byte is eaten and name matching starts over
                if (b == mhurs_pkg::CHAR_LF) begin
                    nx.done = 1'b1;
                end else begin
                    nx.phase = mhurs_pkg::PH_NAME;
                    nx.pos   = 4'd0;
                end
            end
            default: begin
            end
        endcase
        return nx;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one input transaction; the prediction is taken at the accepting edge
    task automatic send_byte(input logic [7:0] raw);
        logic [7:0]  b;
        scan_state_t trial;
        b = raw;
        trial = scan_next(scan_state, b);
        if (keep_alive && trial.done) begin
            b = "x";
        end
        // random sender gaps, valid is held low while the idle draw hits
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        scan_state = scan_next(scan_state, b);
        pending_flags.push_back('{utf8_found: scan_state.utf8, scan_done: scan_state.done});
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // drop valid and hold off until every result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_flags.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] any_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(1) == 1) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] random_letter();
        return any_case(8'("a" + $urandom_range(25)));
    endfunction

    // keyword in random case, some characters spoiled at mangle_pct
    task automatic send_word(input string w, input int len, input int mangle_pct);
        logic [7:0] b;
        for (int i = 0; i < len && i < w.len(); i++) begin
            b = any_case(w[i]);
            if ($urandom_range(99) < mangle_pct) begin
                b = random_letter();
            end
            send_byte(b);
        end
    endtask

    task automatic send_blank();
        send_byte($urandom_range(1) ? mhurs_pkg::CHAR_SP : mhurs_pkg::CHAR_TAB);
    endtask

    task automatic send_line_end();
        if ($urandom_range(1) == 1) begin
            send_byte(mhurs_pkg::CHAR_CR);
        end
        send_byte(mhurs_pkg::CHAR_LF);
    endtask

    // field body text, salted with pieces of the keywords
    task automatic send_filler(input int n);
        string pieces;
        int    r;
        pieces = "with utf8";
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_byte(($urandom_range(4) == 0) ? 8'("0" + $urandom_range(9))
                                                   : random_letter());
            end else if (r < 60) begin
                send_blank();
            end else if (r < 68) begin
                send_byte(mhurs_pkg::CHAR_CR);
            end else if (r < 80) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(any_case(pieces[$urandom_range(pieces.len() - 1)]));
            end
        end
    endtask

    // argument of the with-clause: utf8 whole or cut short, or another tag
    task automatic send_with_arg();
        int n;
        repeat ($urandom_range(2)) send_blank();
        if ($urandom_range(99) < 50) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 4;
            send_word("utf8", n, 4);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(random_letter());
        end
        send_filler($urandom_range(1, 8));
    endtask

    task automatic send_received_line();
        int r;
        send_word("received:", 9, 6);
        send_filler($urandom_range(0, 12));
        r = $urandom_range(99);
        if (r < 25) begin
            // folded: the continuation blank opens the with keyword
            send_line_end();
            send_blank();
            send_word("with", 4, 5);
            send_blank();
            send_with_arg();
        end else if (r < 75) begin
            send_blank();
            send_word("with", 4, 5);
            send_blank();
            send_with_arg();
        end else begin
            send_filler($urandom_range(1, 10));
        end
        send_line_end();
    endtask

    task automatic send_other_line();
        if ($urandom_range(99) < 25) begin
            // lookalike name that breaks off part way
            send_word("received", $urandom_range(1, 8), 0);
        end
        repeat ($urandom_range(1, 8)) send_byte(random_letter());
        send_byte(":");
        send_filler($urandom_range(0, 14));
        send_line_end();
    endtask

    task automatic send_random_line();
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            send_received_line();
        end else if (r < 82) begin
            send_other_line();
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver readiness; a requested hold-off is counted down here
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // score each result transaction against the oldest prediction
    always @(posedge aclk) begin
        scan_flags_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_flags.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t unexpected result transaction: utf8_found=%0b scan_done=%0b",
                             $time, m_utf8_found, m_scan_done);
                end
            end else begin
                want = pending_flags.pop_front();
                if (m_utf8_found !== want.utf8_found) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t utf8_found mismatch: expected %0b, actual %0b",
                                 $time, want.utf8_found, m_utf8_found);
                    end
                end
                if (m_scan_done !== want.scan_done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t scan_done mismatch: expected %0b, actual %0b",
                                 $time, want.scan_done, m_scan_done);
                    end
                end
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // byte extremes, carriage returns, tabs as blanks, mixed-case name,
    // folded with-clause and a non-utf8 argument
    task automatic test_directed_header();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        keep_alive     = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mhurs_pkg::CHAR_LF);
        send_text("ReCeIvEd:\015\n");
        // tab after the newline is the leading blank of the keyword,
        // the tab after it is skipped, x fails the argument, ; is eaten
        send_text("\tWiTh \tx;\n");
    endtask

    // long header of random lines under one idle/stall mix
    task automatic test_random_headers(input int idle_pct, input int stall_pct,
                                       input int count);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        keep_alive     = 1'b1;
        target = items_sent + count;
        while (items_sent < target) begin
            send_random_line();
        end
    endtask

    // receiver stops for a long stretch while bytes keep coming,
    // then the sender waits for the scanner to empty out
    task automatic test_backpressure();
        int target;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        keep_alive     = 1'b1;
        hold_request   = 1'b1;
        target = items_sent + 40;
        while (items_sent < target) begin
            send_random_line();
        end
        wait_drained();
        recv_stall_pct = 30;
        send_received_line();
        send_other_line();
    endtask

    // end the header one of three ways, then bytes that must be ignored
    task automatic test_scan_end();
        int kind;
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        kind = $urandom_range(2);
        if (kind == 0) begin
            send_text("X: y");
            keep_alive = 1'b0;
            send_text("\n\015\n");
        end else begin
            send_text("Z: q\n");
            keep_alive = 1'b0;
            if (kind == 1) begin
                send_text("Received: by h with UTF8\n");
            end else begin
                send_text("rEceived: x WITH e\n");
            end
        end
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mhurs_pkg::CHAR_LF);
        send_byte(mhurs_pkg::CHAR_CR);
        send_text("Received: a with utf8;\n\n");
        repeat (6) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_header();
        test_random_headers(0, 0, ITEMS_PER_MIX);
        test_random_headers(45, 0, ITEMS_PER_MIX);
        test_random_headers(0, 45, ITEMS_PER_MIX);
        test_random_headers(11, 11, ITEMS_PER_MIX);
        test_backpressure();
        test_scan_end();

        // let the last results out, then wait for stragglers
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
